// ===== hdl/mcci_pkg.sv =====
// ----------------------------------------------------------------------------
// mcci_pkg: shared constants for the metronome click and count-in core
// Field widths, register indexes, command codes and reset values.
// ----------------------------------------------------------------------------
package mcci_pkg;

    localparam int SPB_W   = 30;
    localparam int BPB_W   = 5;
    localparam int GAIN_W  = 15;
    localparam int BARS_W  = 2;
    localparam int CNT_W   = 6;
    localparam int DIVS_W  = SPB_W + BPB_W;
    localparam int CFG_IDX_W = 3;

    localparam int CLICK_LEN_DEF = 480;
    localparam int POS_BITS_DEF  = 48;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_RESET = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SPB    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPB    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BARS   = 3'd5;

    localparam logic [SPB_W-1:0]  SPB_RESET  = 30'd6144000;
    localparam logic [BPB_W-1:0]  BPB_RESET  = 5'd4;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd16384;

endpackage

// ===== hdl/metronome_click_and_count_in_core.sv =====
// ----------------------------------------------------------------------------
// metronome_click_and_count_in_core: metronome click and count-in
// One input word per audio sample in, one result word out.
// ----------------------------------------------------------------------------
// Each input word takes one pass of a small sequencer around a single shared
// 1-bit-per-cycle divider of POS_BITS+8 quotient bits. A block-start tick on a
// new beat adds two divisions (beat index, then beat modulo beats_per_bar),
// and an active count-in adds two more (beats and bars elapsed). The input is
// not ready while a word is in progress; a finished result sits in the output
// register and the next word is accepted while it waits. The click waveform
// is a ROM built at elaboration, so no fill pass follows reset. Configuration
// writes are always accepted.
// ----------------------------------------------------------------------------
module metronome_click_and_count_in_core import mcci_pkg::*; #(
    parameter int CLICK_LEN = CLICK_LEN_DEF,
    parameter int POS_BITS  = POS_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // config write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [SPB_W-1:0]        cfg_data,
    // input words
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // tdata: position, playing, block_start (zero fill to bytes)
    input  logic [((POS_BITS+2+7)/8)*8-1:0] s_tdata,
    // tuser: op
    input  logic [1:0]              s_tuser,
    // result words
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // tdata: click_sample, count_beat, count_bar, beats_left, count_done,
    //        click_active
    output logic [31:0]             m_tdata
);
    localparam int QW = POS_BITS + 8;
    localparam int IW = $clog2(CLICK_LEN + 1);
    localparam int AW = $clog2(CLICK_LEN);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_BEAT  = 4'd2;
    localparam logic [3:0] S_ACC   = 4'd3;
    localparam logic [3:0] S_PLAY  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_SAT   = 4'd6;
    localparam logic [3:0] S_COUNT = 4'd7;
    localparam logic [3:0] S_CB1   = 4'd8;
    localparam logic [3:0] S_CB2   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // configuration
    logic [SPB_W-1:0]  spb_reg;
    logic [BPB_W-1:0]  bpb_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              enable_reg, mute_reg;
    logic [BARS_W-1:0] bars_reg;

    // sequencer and state
    logic [3:0]          state_reg, state_next;
    logic [1:0]          op_reg;
    logic [POS_BITS-1:0] pos_reg, e_reg, e_next;
    logic                playing_reg, bstart_reg;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                busy_reg, busy_next;
    logic                accent_reg, accent_next;
    logic [QW-1:0]       last_reg, last_next;
    logic                lb_ok_reg, lb_ok_next;
    logic                counting_reg, counting_next;
    logic [POS_BITS-1:0] cs_reg, cs_next;
    logic                cs_ok_reg, cs_ok_next;
    logic [DIVS_W-1:0]   prod_reg, prod_next;
    logic [QW-1:0]       beats_reg, beats_next;
    logic [31:0]         p_reg, p_next;

    // result being built, and the output register
    logic [15:0]       samp_reg, samp_next;
    logic              act_reg, act_next;
    logic [CNT_W-1:0]  cbeat_reg, cbeat_next, cleft_reg, cleft_next;
    logic [BARS_W-1:0] cbar_reg, cbar_next;
    logic              cdone_reg, cdone_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg, m_data_next;

    // divider
    logic              div_start, div_busy, div_done;
    logic [QW-1:0]     div_a, div_quot;
    logic [DIVS_W-1:0] div_b, div_rem;

    // effective register values
    logic [SPB_W-1:0]  spb_eff;
    logic [BPB_W-1:0]  bpb_eff;
    logic [BARS_W-1:0] bars_eff;
    logic [CNT_W-1:0]  total;
    logic [15:0]       wave;
    logic [15:0]       mag;
    logic [16:0]       gk;
    logic [32:0]       rsum;
    logic [17:0]       rmag;
    logic [DIVS_W:0]   req_full;
    logic [POS_BITS-1:0] req;
    logic [AW-1:0]     rom_addr;

    assign spb_eff  = (spb_reg < SPB_W'(256)) ? SPB_W'(256) : spb_reg;
    assign bpb_eff  = (bpb_reg == '0) ? BPB_W'(1) :
                      ((bpb_reg > BPB_W'(16)) ? BPB_W'(16) : bpb_reg);
    assign bars_eff = (bars_reg == 2'd3) ? 2'd2 : bars_reg;
    assign total    = CNT_W'(bars_eff) * CNT_W'(bpb_eff);

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spb_reg    <= SPB_RESET;
            bpb_reg    <= BPB_RESET;
            gain_reg   <= GAIN_RESET;
            enable_reg <= 1'b0;
            mute_reg   <= 1'b0;
            bars_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SPB:    spb_reg    <= cfg_data;
                CFG_BPB:    bpb_reg    <= cfg_data[BPB_W-1:0];
                CFG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_MUTE:   mute_reg   <= cfg_data[0];
                CFG_BARS:   bars_reg   <= cfg_data[BARS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mcci_div #(.DW(QW), .VW(DIVS_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // idle index past the end reads entry zero; that word is never used
    assign rom_addr = (idx_reg < IW'(CLICK_LEN)) ? idx_reg[AW-1:0] : '0;

    mcci_wave #(.CLICK_LEN(CLICK_LEN)) u_wave (
        .aclk (aclk),
        .addr (rom_addr),
        .data (wave)
    );

    assign s_tready = (state_reg == S_IDLE);

    // click arithmetic: magnitude, gain times accent, round and saturate
    assign mag      = wave[15] ? 16'(0 - wave) : wave;
    assign gk       = accent_reg ? 17'(gain_reg) * 17'd3 : 17'(gain_reg) * 17'd2;
    assign rsum     = 33'(p_reg) + 33'd16384;
    assign rmag     = rsum[32:15];
    assign req_full = (bars_eff == 2'd2) ? {prod_reg, 1'b0} :
                      ((bars_eff == 2'd1) ? {1'b0, prod_reg} : '0);
    assign req      = POS_BITS'(req_full[DIVS_W:8]);

    always_comb begin
        state_next    = state_reg;
        e_next        = e_reg;
        idx_next      = idx_reg;
        busy_next     = busy_reg;
        accent_next   = accent_reg;
        last_next     = last_reg;
        lb_ok_next    = lb_ok_reg;
        counting_next = counting_reg;
        cs_next       = cs_reg;
        cs_ok_next    = cs_ok_reg;
        prod_next     = prod_reg;
        beats_next    = beats_reg;
        p_next        = p_reg;
        samp_next     = samp_reg;
        act_next      = act_reg;
        cbeat_next    = cbeat_reg;
        cbar_next     = cbar_reg;
        cleft_next    = cleft_reg;
        cdone_next    = cdone_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        div_start     = 1'b0;
        div_a         = QW'(pos_reg) << 8;
        div_b         = DIVS_W'(spb_eff);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                samp_next  = '0;
                act_next   = 1'b0;
                prod_next  = DIVS_W'(spb_eff) * DIVS_W'(bpb_eff);
                state_next = S_COUNT;
                case (op_reg)
                    OP_START: begin
                        if (bars_eff != '0) begin
                            counting_next = 1'b1;
                            cs_next       = pos_reg;
                            cs_ok_next    = 1'b1;
                            lb_ok_next    = 1'b0;
                        end
                    end
                    OP_STOP: begin
                        counting_next = 1'b0;
                        cs_ok_next    = 1'b0;
                        lb_ok_next    = 1'b0;
                    end
                    OP_RESET: begin
                        counting_next = 1'b0;
                        cs_ok_next    = 1'b0;
                    end
                    default: begin
                        if (mute_reg || !(playing_reg && (counting_reg || enable_reg))) begin
                            busy_next = 1'b0;
                        end else if (bstart_reg) begin
                            div_start  = 1'b1;
                            state_next = S_BEAT;
                        end else begin
                            state_next = S_PLAY;
                        end
                    end
                endcase
            end
            S_BEAT: begin
                // new beat index restarts the click; find its place in the bar
                if (div_done) begin
                    if (!lb_ok_reg || div_quot != last_reg) begin
                        last_next  = div_quot;
                        lb_ok_next = 1'b1;
                        div_start  = 1'b1;
                        div_a      = div_quot;
                        div_b      = DIVS_W'(bpb_eff);
                        state_next = S_ACC;
                    end else begin
                        state_next = S_PLAY;
                    end
                end
            end
            S_ACC: begin
                if (div_done) begin
                    accent_next = (div_rem == '0);
                    busy_next   = 1'b1;
                    idx_next    = '0;
                    state_next  = S_PLAY;
                end
            end
            S_PLAY: begin
                // ROM read of idx lands at the end of this cycle
                if (!busy_reg) begin
                    state_next = S_COUNT;
                end else if (idx_reg >= IW'(CLICK_LEN)) begin
                    busy_next  = 1'b0;
                    state_next = S_COUNT;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                p_next     = 32'(mag) * 32'(gk);
                state_next = S_SAT;
            end
            S_SAT: begin
                if (wave[15]) begin
                    samp_next = (rmag > 18'd32768) ? 16'h8000 : 16'(0 - rmag);
                end else begin
                    samp_next = (rmag > 18'd32767) ? 16'h7FFF : rmag[15:0];
                end
                act_next   = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = S_COUNT;
            end
            S_COUNT: begin
                cbeat_next = '0;
                cbar_next  = '0;
                cleft_next = '0;
                cdone_next = 1'b1;
                state_next = S_DONE;
                if (counting_reg && cs_ok_reg) begin
                    if (pos_reg < cs_reg) begin
                        cleft_next = total;
                        cdone_next = 1'b0;
                    end else begin
                        e_next     = pos_reg - cs_reg;
                        div_start  = 1'b1;
                        div_a      = QW'(pos_reg - cs_reg) << 8;
                        state_next = S_CB1;
                    end
                end
            end
            S_CB1: begin
                if (div_done) begin
                    beats_next = div_quot;
                    div_start  = 1'b1;
                    div_a      = QW'(e_reg) << 8;
                    div_b      = prod_reg;
                    state_next = S_CB2;
                end
            end
            S_CB2: begin
                if (div_done) begin
                    if (beats_reg >= QW'(total)) begin
                        cbeat_next = total;
                        cleft_next = '0;
                    end else begin
                        cbeat_next = beats_reg[CNT_W-1:0] + 1'b1;
                        cleft_next = total - beats_reg[CNT_W-1:0];
                    end
                    cbar_next  = (div_quot >= QW'(bars_eff)) ? bars_eff :
                                 div_quot[BARS_W-1:0] + 1'b1;
                    cdone_next = (e_reg >= req);
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {act_reg, cdone_reg, cleft_reg, cbar_reg,
                                    cbeat_reg, samp_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            busy_reg     <= 1'b0;
            accent_reg   <= 1'b0;
            lb_ok_reg    <= 1'b0;
            counting_reg <= 1'b0;
            cs_ok_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            busy_reg     <= busy_next;
            accent_reg   <= accent_next;
            lb_ok_reg    <= lb_ok_next;
            counting_reg <= counting_next;
            cs_ok_reg    <= cs_ok_next;
            m_valid_reg  <= m_valid_next;
        end
        if (s_tvalid && s_tready) begin
            op_reg      <= s_tuser;
            pos_reg     <= s_tdata[POS_BITS-1:0];
            playing_reg <= s_tdata[POS_BITS];
            bstart_reg  <= s_tdata[POS_BITS+1];
        end
        e_reg      <= e_next;
        last_reg   <= last_next;
        cs_reg     <= cs_next;
        prod_reg   <= prod_next;
        beats_reg  <= beats_next;
        p_reg      <= p_next;
        samp_reg   <= samp_next;
        act_reg    <= act_next;
        cbeat_reg  <= cbeat_next;
        cbar_reg   <= cbar_next;
        cleft_reg  <= cleft_next;
        cdone_reg  <= cdone_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    // play index never runs past the end of the click
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IW'(CLICK_LEN))
        else $error("click index past end");

    // divider is only started when it is free
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // a word without an active click carries a silent sample
    a_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[31]) |-> (m_data_reg[15:0] == 16'd0))
        else $error("sample without active click");
`endif
endmodule

// ===== hdl/mcci_div.sv =====
// ----------------------------------------------------------------------------
// mcci_div: shared restoring divider
// One quotient bit per cycle; quotient and remainder valid with done.
// ----------------------------------------------------------------------------
module mcci_div import mcci_pkg::*; #(
    parameter int DW = POS_BITS_DEF + 8,
    parameter int VW = DIVS_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quot,
    output logic [VW-1:0] rem
);
    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quot_reg, quot_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, quot_reg[DW-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? VW'(trial - {1'b0, dvs_reg}) : VW'(trial);
            quot_next = {quot_reg[DW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;
endmodule

// ===== hdl/mcci_wave.sv =====
// ----------------------------------------------------------------------------
// mcci_wave: click waveform ROM
// Decaying 1 kHz sine, Q15, built at elaboration; registered read.
// ----------------------------------------------------------------------------
module mcci_wave import mcci_pkg::*; #(
    parameter int CLICK_LEN = CLICK_LEN_DEF
) (
    input  logic                         aclk,
    input  logic [$clog2(CLICK_LEN)-1:0] addr,
    output logic [15:0]                  data
);
    logic [15:0] wave_rom [CLICK_LEN];
    logic [15:0] data_reg;

    // Q30 Taylor series of sin through x^9, scaled to Q15
    function automatic logic [14:0] sine_q15(input logic [63:0] u);
        logic [63:0] x, x2, t, s, r;
        x  = (u * 64'd1686629713) >> 16;
        x2 = (x * x) >> 30;
        t  = (64'd1 << 30) - x2 / 64'd72;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        r  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        return (r > 64'd32767) ? 15'd32767 : r[14:0];
    endfunction

    for (genvar g = 0; g < CLICK_LEN; g++) begin : g_rom
        localparam longint unsigned Q    = (g * 10) % CLICK_LEN;
        localparam longint unsigned P4   = Q * 4;
        localparam longint unsigned QUAD = P4 / CLICK_LEN;
        localparam longint unsigned U0   = ((P4 % CLICK_LEN) * 65536) / CLICK_LEN;
        localparam longint unsigned U    = (QUAD % 2 == 1) ? 65536 - U0 : U0;
        localparam longint unsigned M    = 64'(sine_q15(64'(U)));
        localparam longint unsigned MM   = (M * (CLICK_LEN - g)) / CLICK_LEN;
        localparam logic [15:0]     W    = (QUAD >= 2) ? 16'(65536 - MM) : 16'(MM);
        assign wave_rom[g] = W;
    end

    always_ff @(posedge aclk) begin
        data_reg <= wave_rom[addr];
    end

    assign data = data_reg;
endmodule

// ===== dv/tb_metronome_click_and_count_in_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_metronome_click_and_count_in_core: metronome core testbench
// Drives sample ticks and count-in commands through the stream ports, writes
// the registers between phases, predicts every result word with a behavioral
// model of the click ROM, beat tracking and count-in logic, and compares each
// result field by field under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_metronome_click_and_count_in_core;
    import mcci_pkg::*;

    localparam int CLK_LEN = CLICK_LEN_DEF;
    localparam int PBITS   = POS_BITS_DEF;
    localparam int TDW     = ((PBITS + 2 + 7) / 8) * 8;
    localparam longint CYCLE_LIMIT = 4000000;

    // most significant field first: click_sample sits in the low bits
    typedef struct packed {
        logic        active;
        logic        done;
        logic [5:0]  left;
        logic [1:0]  bar;
        logic [5:0]  beat;
        logic [15:0] click;
    } click_word_t;

    // ------------------------------------------------------------------
    // Behavioral model of the metronome and the store of expected words
    // ------------------------------------------------------------------
    class click_scoreboard;
        int            wave[CLK_LEN];
        int unsigned   play_pos;
        bit            playing_click, accent;
        longint unsigned last_beat_idx;
        bit            last_beat_ok, counting, start_ok;
        longint unsigned start_pos;
        longint unsigned spb, bpb, gain, enable, mute, bars;
        click_word_t   pending[$];
        int            errors;

        // Q15 sine of a quadrant offset, fixed-point Taylor series
        function automatic int unsigned sine_q15(longint unsigned u);
            longint unsigned one, x, x2, t, s, r;
            one = 64'd1 << 30;
            x  = (u * 64'd1686629713) >> 16;
            x2 = (x * x) >> 30;
            t  = one - x2 / 72;
            t  = one - ((x2 * t) >> 30) / 42;
            t  = one - ((x2 * t) >> 30) / 20;
            t  = one - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            r  = (s * 32767 + (64'd1 << 29)) >> 30;
            return (r > 32767) ? 32767 : int'(r);
        endfunction

        function new();
            longint unsigned q, p4, quad, u, m;
            for (int i = 0; i < CLK_LEN; i++) begin
                q = (i * 10) % CLK_LEN;
                p4 = q * 4;
                quad = p4 / CLK_LEN;
                u = ((p4 % CLK_LEN) * 65536) / CLK_LEN;
                if (quad[0]) u = 65536 - u;
                m = sine_q15(u);
                m = (m * (CLK_LEN - i)) / CLK_LEN;
                wave[i] = quad[1] ? -int'(m) : int'(m);
            end
            spb = SPB_RESET; bpb = BPB_RESET; gain = GAIN_RESET;
            enable = 0; mute = 0; bars = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPB_W-1:0] val);
            case (idx)
                CFG_SPB:    spb = val;
                CFG_BPB:    bpb = val[4:0];
                CFG_GAIN:   gain = val[14:0];
                CFG_ENABLE: enable = val[0];
                CFG_MUTE:   mute = val[0];
                CFG_BARS:   bars = val[1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned spb_e();
            return (spb < 256) ? 256 : spb;
        endfunction
        function longint unsigned bpb_e();
            return (bpb == 0) ? 1 : ((bpb > 16) ? 16 : bpb);
        endfunction
        function longint unsigned bars_e();
            return (bars > 2) ? 2 : bars;
        endfunction

        function longint unsigned div_q8(longint unsigned e, longint unsigned d);
            return (e / d) * 256 + ((e % d) * 256) / d;
        endfunction

        function void count_in_fields(longint unsigned pos, ref click_word_t w);
            longint unsigned sp, bp, br, total, e, beats, bar, req;
            sp = spb_e(); bp = bpb_e(); br = bars_e();
            total = br * bp;
            w.beat = 0; w.bar = 0; w.left = 0; w.done = 1;
            if (!counting || !start_ok) return;
            if (pos < start_pos) begin
                w.left = total; w.done = 0;
                return;
            end
            e = pos - start_pos;
            beats = div_q8(e, sp);
            bar = div_q8(e, sp * bp);
            w.beat = (beats >= total) ? total : beats + 1;
            w.bar  = (bar >= br) ? br : bar + 1;
            w.left = (beats >= total) ? 0 : total - beats;
            req = (sp * bp * br) >> 8;
            w.done = (e >= req);
        endfunction

        // note an accepted input word and queue its expected result
        function void note_input(logic [1:0] op, logic [PBITS-1:0] pos_in,
                                 bit play, bit bstart);
            click_word_t w;
            longint unsigned pos, beat, mag, r;
            int sv;
            pos = pos_in;
            w = '0;
            case (op)
                OP_START: if (bars_e() > 0) begin
                    counting = 1; start_pos = pos; start_ok = 1; last_beat_ok = 0;
                end
                OP_STOP: begin
                    counting = 0; start_ok = 0; last_beat_ok = 0;
                end
                OP_RESET: begin
                    counting = 0; start_ok = 0;
                end
                default: begin
                    if (mute != 0 || !(play && (counting || enable != 0))) begin
                        playing_click = 0;
                    end else begin
                        if (bstart) begin
                            beat = div_q8(pos, spb_e());
                            if (!last_beat_ok || beat != last_beat_idx) begin
                                last_beat_idx = beat; last_beat_ok = 1;
                                playing_click = 1; play_pos = 0;
                                accent = (beat % bpb_e()) == 0;
                            end
                        end
                        if (playing_click) begin
                            if (play_pos >= CLK_LEN) begin
                                playing_click = 0;
                            end else begin
                                sv = wave[play_pos];
                                mag = (sv < 0) ? -sv : sv;
                                r = (mag * gain * (accent ? 3 : 2) + 16384) >> 15;
                                if (sv < 0) begin
                                    if (r > 32768) r = 32768;
                                    w.click = 16'(-r);
                                end else begin
                                    w.click = (r > 32767) ? 16'd32767 : 16'(r);
                                end
                                w.active = 1;
                                play_pos++;
                            end
                        end
                    end
                end
            endcase
            count_in_fields(pos, w);
            pending.push_back(w);
        endfunction

        // check one result word against the oldest expectation
        function void check_result(logic [31:0] data);
            click_word_t got, exp_w;
            got = data;
            if (pending.size() == 0) begin
                $error("result word with no expectation: %h", data);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.click !== exp_w.click) begin
                $error("click_sample exp %0d got %0d", $signed(exp_w.click), $signed(got.click));
                errors++;
            end
            if (got.beat !== exp_w.beat) begin
                $error("count_beat exp %0d got %0d", exp_w.beat, got.beat); errors++;
            end
            if (got.bar !== exp_w.bar) begin
                $error("count_bar exp %0d got %0d", exp_w.bar, got.bar); errors++;
            end
            if (got.left !== exp_w.left) begin
                $error("beats_left exp %0d got %0d", exp_w.left, got.left); errors++;
            end
            if (got.done !== exp_w.done) begin
                $error("count_done exp %0d got %0d", exp_w.done, got.done); errors++;
            end
            if (got.active !== exp_w.active) begin
                $error("click_active exp %0d got %0d", exp_w.active, got.active); errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SPB_W-1:0] cfg_data = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [TDW-1:0] s_tdata = '0;   // position, playing, block_start
    logic [1:0] s_tuser = OP_TICK;  // op
    logic m_tvalid;
    logic m_tready = 0;
    logic [31:0] m_tdata;           // click, beat, bar, left, done, active

    always #6 aclk = ~aclk;

    metronome_click_and_count_in_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    click_scoreboard sb = new();
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    bit hold_off = 0;
    longint cycles = 0;

    // Cycle counter with a hard stop far above the slowest legal run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_metronome_click_and_count_in_core NOT OK");
            $finish;
        end
    end

    // Sink: stall at random, or hold off entirely during pressure phase
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
    end

    // Source: drop valid while idling, offer one word and hold it until the
    // handshake; valid stays up so a back-to-back word follows directly
    task automatic send_word(logic [1:0] op, logic [PBITS-1:0] pos, bit play, bit bstart);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {{(TDW - PBITS - 2){1'b0}}, bstart, play, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, pos, play, bstart);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPB_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // Drop valid, wait until every expected word arrived, then let the core settle
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic set_all(logic [SPB_W-1:0] spb, logic [4:0] bpb, logic [14:0] gain,
                           bit en, bit mute, logic [1:0] bars);
        drain();
        write_reg(CFG_SPB, spb);
        write_reg(CFG_BPB, bpb);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_ENABLE, en);
        write_reg(CFG_MUTE, mute);
        write_reg(CFG_BARS, bars);
    endtask

    // Mostly well-formed playback: a run of ticks with random count-in start,
    // stop and reset commands, block_start high on about one word in four
    task automatic random_phase(int n);
        logic [PBITS-1:0] pos;
        logic [1:0] op;
        int r;
        pos = {$urandom, $urandom} & ((64'd1 << PBITS) - 1);
        if ($urandom_range(3) == 0) pos = {$urandom_range(255)};
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            op = OP_TICK;
            if (r < 4) op = OP_START;
            else if (r < 6) op = OP_STOP;
            else if (r < 8) op = OP_RESET;
            if (r >= 97) pos = {$urandom, $urandom};
            else if (r >= 94) pos = pos - $urandom_range(4000);
            else pos = pos + $urandom_range(1, 60);
            send_word(op, pos, $urandom_range(15) != 0, $urandom_range(3) == 0);
        end
    endtask

    initial begin
        logic [PBITS-1:0] p;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset settings, then count-in edge cases
        send_word(OP_TICK, '0, 1, 1);
        send_word(OP_START, 48'd100, 1, 0);          // zero bars: no effect
        set_all(30'd100, 5'd0, 15'h7FFF, 1, 0, 2'd3); // clamp spb, bpb, bars
        send_word(OP_START, 48'd1000, 1, 0);
        send_word(OP_TICK, 48'd999, 1, 1);            // before count start
        send_word(OP_TICK, 48'd1000, 1, 1);
        send_word(OP_TICK, 48'd1001, 1, 0);
        send_word(OP_TICK, 48'd1003, 1, 1);           // count-in done
        send_word(OP_TICK, '1, 1, 1);
        send_word(OP_RESET, '1, 0, 0);
        send_word(OP_TICK, '1, 1, 1);
        send_word(OP_STOP, 48'd5, 1, 1);
        set_all(30'h3FFFFFFF, 5'd31, 15'd0, 1, 1, 2'd1); // mute, huge spb
        send_word(OP_TICK, 48'd7, 1, 1);
        send_word(OP_START, '0, 1, 1);
        send_word(OP_TICK, 48'h800000000000, 1, 1);
        // click runs past its end: beats longer than the click so playback does not restart
        set_all(30'd256 * 600, 5'd16, 15'h7FFF, 1, 0, 2'd0);
        p = 0;
        for (int i = 0; i < CLK_LEN + 4; i++) begin
            send_word(OP_TICK, p, 1, i == 0);
            p++;
        end
        send_word(OP_TICK, p, 0, 1);

        // Random phases across idle and stall mixes and settings
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct  = (ph == 1) ? 66 : (ph == 3) ? 38 : 0;
            snk_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 38 : 0;
            set_all(ph[0] ? 30'd256 * $urandom_range(2, 40) : 30'($urandom_range(256, 6000)),
                    5'($urandom_range(1, 16)), 15'($urandom), ph != 2, 0,
                    2'($urandom_range(3)));
            random_phase(25);
        end

        // Pressure: sink holds off while source keeps offering
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end
            begin
                random_phase(10);
                s_tvalid <= 0;
            end
        join

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_metronome_click_and_count_in_core OK");
        end else begin
            $display("tb_metronome_click_and_count_in_core NOT OK");
        end
        $finish;
    end
endmodule
